// ----- rtl/bspt_pkg.sv -----
// Package for the quadratic B-spline point tessellator.
// Item types, register indexes, step table and helpers; no dependencies.
package bspt_pkg;

	// Configuration
	localparam int MAX_PIECES = 32;
	localparam int SEG_MIN    = 2;
	localparam int SEG_MAX    = 1024;
	localparam int SEG_W      = 11;
	localparam int PIECES_W   = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIECES        = 1'd1;

	localparam logic [SEG_W-1:0]    SEG_RESET    = 11'd12;
	localparam logic [PIECES_W-1:0] PIECES_RESET = 6'd20;

	// Arithmetic widths
	localparam int POINT_W  = 32;
	localparam int WEIGHT_W = 18;
	localparam int PROD_W   = POINT_W + WEIGHT_W;
	localparam int FRAC_W   = 16;
	localparam int T_W      = 17;

	// Parameter step per piece: floor(65536 / pieces), entry 0 unused
	localparam logic [T_W-1:0] STEP_TAB [MAX_PIECES+1] = '{
		17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107,
		17'd10922, 17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,
		17'd5461,  17'd5041,  17'd4681,  17'd4369,  17'd4096,  17'd3855,
		17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,
		17'd2730,  17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,
		17'd2184,  17'd2114,  17'd2048
	};

	typedef struct packed {
		logic signed [POINT_W-1:0] point_x;
		logic signed [POINT_W-1:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic               run_last;
	} out_item_t;

	// Tag that travels with a product into the accumulators
	typedef struct packed {
		logic en;
		logic is_y;
		logic first;
	} mac_op_t;

	// Halve the 16.16 sum, take the integer part, keep 16 bits
	function automatic logic signed [15:0] to_pixel(input logic [POINT_W-1:0] s);
		to_pixel = {s[31], s[31:17]};
	endfunction

endpackage

// ----- rtl/bspt_mac.sv -----
// Shared multiply-accumulate unit of the tessellator.
// Registered 18x32 signed product, then x and y accumulators; uses bspt_pkg.
module bspt_mac import bspt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mac_op_t                    op,
	input  logic signed [WEIGHT_W-1:0] w,
	input  logic signed [POINT_W-1:0]  p,
	output logic signed [PROD_W-1:0]   prod,
	output logic [POINT_W-1:0]         acc_x,
	output logic [POINT_W-1:0]         acc_y
);

	logic signed [PROD_W-1:0] prod_s1;
	mac_op_t                  tag_s1;
	logic [POINT_W-1:0]       acc_x_q;
	logic [POINT_W-1:0]       acc_y_q;
	logic [POINT_W-1:0]       part;

	// product stage
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(w) * PROD_W'(p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= op;
		end
	end

	// (w*p)>>16 kept to 32 bits
	assign part = prod_s1[FRAC_W+POINT_W-1:FRAC_W];

	// accumulate, wrapping at 32 bits
	always_ff @(posedge clk) begin
		if (tag_s1.en) begin
			if (tag_s1.is_y) begin
				acc_y_q <= tag_s1.first ? part : acc_y_q + part;
			end else begin
				acc_x_q <= tag_s1.first ? part : acc_x_q + part;
			end
		end
	end

	assign prod  = prod_s1;
	assign acc_x = acc_x_q;
	assign acc_y = acc_y_q;

endmodule

// ----- rtl/quadratic_bspline_point_tessellator_unit.sv -----
// Top level of the quadratic B-spline point tessellator.
// Holds the point history, sequencer and output register; uses bspt_pkg and bspt_mac.
//
// Usage: control points enter on in_item (valid/stall), curve points leave on
// out_item (valid/stall). The first point of a curve only primes the history
// and gives no item. Each later point gives one run of pieces_per_segment
// points; the last point of a curve (segment_count points per curve) gives a
// second run for the closing segment. run_last marks the final point of the
// items produced for one input.
// Sequence: every curve point runs on the one shared multiplier through the
// square for t^2 (ST_SQ), the weight step (ST_T2), six weighted products
// (ST_MUL), a drain step (ST_DRAIN) and the output load (ST_OUT); the last
// point of a curve goes through this for both of its runs, and the first
// point of a curve is only accepted. in_stall is high from the cycle after a
// later point is accepted until its final point is loaded. A finished point
// waits in the output register while out_stall is high and the sequencer
// holds until that register frees up. Reset: history and point counter clear,
// segment_count returns to 12 and pieces_per_segment to 20. Configuration must be
// written by the user only while the block is idle; the block does not enforce it.
module quadratic_bspline_point_tessellator_unit import bspt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SQ    = 3'd1;
	localparam logic [2:0] ST_T2    = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [2:0] STEP_LAST = 3'd5;
	localparam logic [2:0] STEP_Y0   = 3'd3;

	logic [2:0]          state_q;
	logic [2:0]          step_q;
	logic [4:0]          piece_q;
	logic                run_q;
	logic                last_item_q;
	logic [T_W-1:0]      t_q;
	logic [15:0]         t2_q;
	logic [9:0]          points_seen_q;
	logic [SEG_W-1:0]    seg_q;
	logic [PIECES_W-1:0] pieces_q;
	in_item_t            older_q;
	in_item_t            newer_q;
	in_item_t            cur_q;
	out_item_t           out_item_q;
	logic                out_valid_q;

	logic [PIECES_W-1:0] p_eff;
	logic [SEG_W-1:0]    seg_eff;
	logic [SEG_W-1:0]    last_idx;
	logic                is_last;
	logic                in_acc;
	logic                piece_done;
	logic                run_last_w;
	logic                load;
	logic [15:0]         t16;
	logic [18:0]         w1_full;
	logic [18:0]         w2_full;
	logic signed [WEIGHT_W-1:0] w1;
	logic signed [WEIGHT_W-1:0] w2;
	logic signed [WEIGHT_W-1:0] w3;
	logic signed [WEIGHT_W-1:0] w_sel;
	logic signed [POINT_W-1:0]  p_sel;
	in_item_t            pa;
	in_item_t            pb;
	mac_op_t             op;
	logic signed [PROD_W-1:0] prod;
	logic [POINT_W-1:0]  acc_x;
	logic [POINT_W-1:0]  acc_y;

	// saturated configuration
	always_comb begin
		if (pieces_q == '0) begin
			p_eff = 6'd1;
		end else if (pieces_q > PIECES_W'(MAX_PIECES)) begin
			p_eff = PIECES_W'(MAX_PIECES);
		end else begin
			p_eff = pieces_q;
		end
		if (seg_q < SEG_W'(SEG_MIN)) begin
			seg_eff = SEG_W'(SEG_MIN);
		end else if (seg_q > SEG_W'(SEG_MAX)) begin
			seg_eff = SEG_W'(SEG_MAX);
		end else begin
			seg_eff = seg_q;
		end
	end

	assign last_idx = seg_eff - 11'd1;
	assign is_last  = {1'b0, points_seen_q} >= last_idx;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// piece and run bookkeeping
	assign piece_done = ({1'b0, piece_q} == p_eff - 6'd1);
	assign run_last_w = piece_done && (run_q || !last_item_q);
	assign load       = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// weights from t and t^2, all non-negative
	assign t16     = t_q[15:0];
	assign w1_full = 19'd65536 + {3'b0, t2_q} - {2'b0, t16, 1'b0};
	assign w2_full = 19'd65536 + {2'b0, t16, 1'b0} - {2'b0, t2_q, 1'b0};
	assign w1      = signed'(w1_full[WEIGHT_W-1:0]);
	assign w2      = signed'(w2_full[WEIGHT_W-1:0]);
	assign w3      = signed'({2'b0, t2_q});

	// control points of the current run
	assign pa = run_q ? newer_q : older_q;
	assign pb = run_q ? cur_q : newer_q;

	// operand select for the shared unit
	always_comb begin
		op    = '0;
		w_sel = w3;
		p_sel = cur_q.point_x;
		if (state_q == ST_SQ) begin
			w_sel = signed'({2'b0, t16});
			p_sel = signed'({16'b0, t16});
		end else if (state_q == ST_MUL) begin
			op.en    = 1'b1;
			op.is_y  = (step_q >= STEP_Y0);
			op.first = (step_q == 3'd0) || (step_q == STEP_Y0);
			case (step_q)
				3'd0: begin w_sel = w3; p_sel = cur_q.point_x; end
				3'd1: begin w_sel = w2; p_sel = pb.point_x; end
				3'd2: begin w_sel = w1; p_sel = pa.point_x; end
				3'd3: begin w_sel = w3; p_sel = cur_q.point_y; end
				3'd4: begin w_sel = w2; p_sel = pb.point_y; end
				default: begin w_sel = w1; p_sel = pa.point_y; end
			endcase
		end
	end

	bspt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.w      (w_sel),
		.p      (p_sel),
		.prod   (prod),
		.acc_x  (acc_x),
		.acc_y  (acc_y)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q    <= SEG_RESET;
			pieces_q <= PIECES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEGMENT_COUNT: seg_q    <= cfg_data[SEG_W-1:0];
				REG_PIECES:        pieces_q <= cfg_data[PIECES_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and point history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			piece_q       <= '0;
			run_q         <= 1'b0;
			last_item_q   <= 1'b0;
			t_q           <= '0;
			points_seen_q <= '0;
			older_q       <= '0;
			newer_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (points_seen_q == '0) begin
							older_q       <= in_item;
							newer_q       <= in_item;
							points_seen_q <= 10'd1;
						end else begin
							last_item_q   <= is_last;
							points_seen_q <= is_last ? 10'd0 : points_seen_q + 10'd1;
							run_q         <= 1'b0;
							piece_q       <= '0;
							t_q           <= '0;
							step_q        <= '0;
							state_q       <= ST_SQ;
						end
					end
				end
				ST_SQ: state_q <= ST_T2;
				ST_T2: state_q <= ST_MUL;
				ST_MUL: begin
					if (step_q == STEP_LAST) begin
						step_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DRAIN: state_q <= ST_OUT;
				ST_OUT: begin
					if (load) begin
						if (!piece_done) begin
							piece_q <= piece_q + 5'd1;
							t_q     <= t_q + STEP_TAB[p_eff];
							state_q <= ST_SQ;
						end else if (!run_q && last_item_q) begin
							// closing segment repeats the last point
							run_q   <= 1'b1;
							piece_q <= '0;
							t_q     <= '0;
							state_q <= ST_SQ;
						end else begin
							older_q <= newer_q;
							newer_q <= cur_q;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload captures
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_q <= in_item;
		end
		if (state_q == ST_T2) begin
			t2_q <= prod[FRAC_W+15:FRAC_W];
		end
		if (load) begin
			out_item_q.pixel_x  <= to_pixel(acc_x);
			out_item_q.pixel_y  <= to_pixel(acc_y);
			out_item_q.run_last <= run_last_w;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// checks
	a_piece_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, piece_q} < p_eff))
		else $error("piece counter beyond pieces per segment");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !t_q[T_W-1])
		else $error("curve parameter reached one");

	a_second_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && (state_q != ST_IDLE) |-> last_item_q)
		else $error("closing run on a point that is not last");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load && run_last_w |=> (state_q == ST_IDLE) && out_valid && out_item.run_last)
		else $error("sequencer not idle after final point of an item");

endmodule
